/* hdl/thc_pkg.sv */
// Shared constants and codes for the thermostat hysteresis safety controller.
package thc_pkg;

  // Default widths for the temperature path and the hold counter.
  localparam int TEMP_WIDTH_DEF = 14;
  localparam int HOLD_WIDTH_DEF = 16;

  // Fixed widths of the remaining configuration and channel fields.
  localparam int BAND_W     = 8;
  localparam int STEP_W     = 8;
  localparam int HOLD_CFG_W = 16;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;

  // Item operation codes.
  localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd0;
  localparam logic [OP_W-1:0] OP_MODE     = 2'd1;
  localparam logic [OP_W-1:0] OP_SETPOINT = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd5;

  // Reset values, in quarter degrees Celsius or milliseconds.
  localparam int MIN_VALID_RST = -1080;
  localparam int MAX_VALID_RST = 5600;
  localparam int LIMIT_RST     = 5200;
  localparam int BAND_RST      = 8;
  localparam int STEP_RST      = 20;
  localparam int HOLD_RST      = 500;
  localparam int SETPOINT_RST  = 400;

endpackage

/* hdl/thermostat_hysteresis_safety_controller.sv */
// Top level of the on/off thermostat with sensor checks and emergency stop.
//
//   Channel | Direction | Handshake              | Word
//   in_     | input     | in_valid / in_stall    | op, reading, fault, turn, buttons
//   out_    | output    | out_valid / out_stall  | heater, error, mode, target, temp, estop
//   cfg_    | input     | cfg_valid / cfg_ready  | register index and data
//
// Each word passes an input register, then one pass of compares and adds that
// updates the state and loads the result register. A new word is accepted in
// every cycle unless the result is stalled; the state update sets that figure.
// Reset (rst_n low at a clock edge) restores config and state and empties both stages.
// A stalled result holds the state; the input register still takes one more word.
// Configuration writes are always ready and take effect in the next cycle.
module thermostat_hysteresis_safety_controller
  import thc_pkg::*;
#(
  parameter int TEMP_WIDTH = TEMP_WIDTH_DEF,
  parameter int HOLD_WIDTH = HOLD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [OP_W-1:0]               in_op,
  input  logic signed [TEMP_WIDTH-1:0]  in_temp_reading,
  input  logic                          in_reading_fault,
  input  logic                          in_turn_up,
  input  logic                          in_left_button_down,
  input  logic                          in_right_button_down,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_heater_on,
  output logic                          out_sensor_error,
  output logic                          out_manual_mode,
  output logic [TEMP_WIDTH-2:0]         out_target_temp,
  output logic signed [TEMP_WIDTH-1:0]  out_measured_temp,
  output logic                          out_estop_fired,
  // Configuration channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [((TEMP_WIDTH > HOLD_CFG_W) ? TEMP_WIDTH : HOLD_CFG_W)-1:0] cfg_data
);

  localparam int TW    = TEMP_WIDTH;
  localparam int XW    = TEMP_WIDTH + 1;
  localparam int CMP_W = (HOLD_WIDTH > HOLD_CFG_W) ? HOLD_WIDTH : HOLD_CFG_W;

  // Configuration registers.
  logic signed [TW-1:0]    min_valid_r;
  logic signed [TW-1:0]    max_valid_r;
  logic [TW-2:0]           limit_r;
  logic [BAND_W-1:0]       band_r;
  logic [STEP_W-1:0]       step_r;
  logic [HOLD_CFG_W-1:0]   hold_ticks_r;

  // Input register stage.
  logic                    s1_valid_r;
  logic [OP_W-1:0]         s1_op_r;
  logic signed [TW-1:0]    s1_reading_r;
  logic                    s1_fault_r;
  logic                    s1_up_r;
  logic                    s1_left_r;
  logic                    s1_right_r;

  // Controller state; it also serves as the result word.
  logic                    mode_r, mode_nxt;
  logic                    heating_r, heating_nxt;
  logic                    error_r, error_nxt;
  logic signed [TW-1:0]    current_r, current_nxt;
  logic [TW-2:0]           setpoint_r, setpoint_nxt;
  logic [HOLD_WIDTH-1:0]   press_cnt_r, press_cnt_nxt;
  logic                    both_held_r, both_held_nxt;
  logic                    estop_done_r, estop_done_nxt;
  logic                    fired_r, fired_nxt;
  logic                    out_valid_r;

  // Intermediate values of the single pass.
  logic                    advance;
  logic                    sample_bad;
  logic signed [XW-1:0]    cur_x;
  logic signed [XW-1:0]    limit_x;
  logic signed [XW-1:0]    setpoint_x;
  logic signed [XW-1:0]    on_thresh;
  logic [TW-1:0]           sp_sum;
  logic [TW-1:0]           sp_diff;
  logic [CMP_W-1:0]        cnt_cmp;
  logic [CMP_W-1:0]        hold_cmp;

  // The compute stage moves unless a finished word is waiting downstream.
  assign advance   = !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_valid_r  <= TW'(MIN_VALID_RST);
      max_valid_r  <= TW'(MAX_VALID_RST);
      limit_r      <= (TW-1)'(LIMIT_RST);
      band_r       <= BAND_W'(BAND_RST);
      step_r       <= STEP_W'(STEP_RST);
      hold_ticks_r <= HOLD_CFG_W'(HOLD_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_VALID: min_valid_r  <= cfg_data[TW-1:0];
        CFG_MAX_VALID: max_valid_r  <= cfg_data[TW-1:0];
        CFG_LIMIT:     limit_r      <= cfg_data[TW-2:0];
        CFG_BAND:      band_r       <= cfg_data[BAND_W-1:0];
        CFG_STEP:      step_r       <= cfg_data[STEP_W-1:0];
        CFG_HOLD:      hold_ticks_r <= cfg_data[HOLD_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: valid bit under reset, payload loaded on acceptance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r      <= in_op;
      s1_reading_r <= in_temp_reading;
      s1_fault_r   <= in_reading_fault;
      s1_up_r      <= in_turn_up;
      s1_left_r    <= in_left_button_down;
      s1_right_r   <= in_right_button_down;
    end
  end

  // Range check of the incoming sample.
  assign sample_bad = s1_fault_r || (s1_reading_r < min_valid_r) ||
                      (s1_reading_r > max_valid_r);

  // Setpoint step arithmetic, one bit wider to catch overflow and borrow.
  assign sp_sum  = TW'(setpoint_r) + TW'(step_r);
  assign sp_diff = TW'(setpoint_r) - TW'(step_r);

  // Single pass: update the state for the word in the input register.
  always_comb begin
    mode_nxt       = mode_r;
    heating_nxt    = heating_r;
    error_nxt      = error_r;
    current_nxt    = current_r;
    setpoint_nxt   = setpoint_r;
    press_cnt_nxt  = press_cnt_r;
    both_held_nxt  = both_held_r;
    estop_done_nxt = estop_done_r;
    fired_nxt      = 1'b0;

    // The heater decision looks at the sample as it was just stored.
    cur_x      = XW'(current_r);
    if (s1_op_r == OP_SAMPLE && !sample_bad) begin
      cur_x = XW'(s1_reading_r);
    end
    limit_x    = signed'(XW'(limit_r));
    setpoint_x = signed'(XW'(setpoint_r));
    on_thresh  = setpoint_x - signed'(XW'(band_r));
    cnt_cmp    = '0;
    hold_cmp   = CMP_W'(hold_ticks_r);

    case (s1_op_r)
      OP_SAMPLE: begin
        error_nxt = sample_bad;
        if (!sample_bad) begin
          current_nxt = s1_reading_r;
        end
        if (sample_bad || !mode_r || setpoint_x > limit_x || cur_x >= limit_x) begin
          heating_nxt = 1'b0;
        end else if (cur_x < on_thresh) begin
          heating_nxt = 1'b1;
        end else if (cur_x > setpoint_x) begin
          heating_nxt = 1'b0;
        end
      end
      OP_MODE: begin
        mode_nxt = !mode_r;
      end
      OP_SETPOINT: begin
        if (s1_up_r) begin
          if (sp_sum > TW'(limit_r)) begin
            setpoint_nxt = limit_r;
          end else begin
            setpoint_nxt = sp_sum[TW-2:0];
          end
        end else if (sp_diff[TW-1]) begin
          setpoint_nxt = '0;
        end else begin
          setpoint_nxt = sp_diff[TW-2:0];
        end
      end
      OP_TICK: begin
        if (s1_left_r && s1_right_r) begin
          // Both buttons down: start or extend the hold, saturating.
          if (!both_held_r) begin
            both_held_nxt = 1'b1;
            press_cnt_nxt = '0;
          end else if (press_cnt_r != {HOLD_WIDTH{1'b1}}) begin
            press_cnt_nxt = press_cnt_r + 1'b1;
          end
          cnt_cmp = CMP_W'(press_cnt_nxt);
          if (cnt_cmp >= hold_cmp && !estop_done_r) begin
            mode_nxt       = 1'b0;
            heating_nxt    = 1'b0;
            estop_done_nxt = 1'b1;
            fired_nxt      = 1'b1;
          end
        end else begin
          press_cnt_nxt  = '0;
          both_held_nxt  = 1'b0;
          estop_done_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      mode_r       <= 1'b0;
      heating_r    <= 1'b0;
      error_r      <= 1'b0;
      current_r    <= '0;
      setpoint_r   <= (TW-1)'(SETPOINT_RST);
      press_cnt_r  <= '0;
      both_held_r  <= 1'b0;
      estop_done_r <= 1'b0;
      fired_r      <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        mode_r       <= mode_nxt;
        heating_r    <= heating_nxt;
        error_r      <= error_nxt;
        current_r    <= current_nxt;
        setpoint_r   <= setpoint_nxt;
        press_cnt_r  <= press_cnt_nxt;
        both_held_r  <= both_held_nxt;
        estop_done_r <= estop_done_nxt;
        fired_r      <= fired_nxt;
      end
    end
  end

  // Result word.
  assign out_valid         = out_valid_r;
  assign out_heater_on     = heating_r;
  assign out_sensor_error  = error_r;
  assign out_manual_mode   = mode_r;
  assign out_target_temp   = setpoint_r;
  assign out_measured_temp = current_r;
  assign out_estop_fired   = fired_r;

  // The heater is never driven while the sensor is in error.
  a_heater_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    heating_r |-> !error_r)
    else $error("heater on with sensor error");

  // A completed stop belongs to a hold in progress.
  a_done_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    estop_done_r |-> both_held_r)
    else $error("emergency stop done outside a hold");

  // A firing stop leaves idle mode and the heater off in the same word.
  a_fire_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fired_r) |-> (!mode_r && !heating_r))
    else $error("emergency stop did not force idle and heater off");

  // A word held in the input register moves on once the result is taken.
  a_stage_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) ##1 !out_stall |=> out_valid_r)
    else $error("input stage word lost after stall");

endmodule

/* dv/tb_thermostat_hysteresis_safety_controller.sv */
// Self-checking testbench for the thermostat hysteresis safety controller.
module tb_thermostat_hysteresis_safety_controller;
  import thc_pkg::*;

  localparam int TW           = TEMP_WIDTH_DEF;
  localparam int CFG_DW       = (TW > HOLD_CFG_W) ? TW : HOLD_CFG_W;
  localparam int HOLD_SAT     = (1 << HOLD_WIDTH_DEF) - 1;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLDOFF = 120;
  localparam int NOIDLE_HOLD  = 37;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic signed [TW-1:0] temp;
    logic                 fault;
    logic                 up;
    logic                 left;
    logic                 right;
  } ctl_word_t;

  typedef struct packed {
    logic                 heater;
    logic                 err;
    logic                 manual;
    logic [TW-2:0]        target;
    logic signed [TW-1:0] measured;
    logic                 estop;
  } status_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op = OP_SAMPLE;
  logic signed [TW-1:0] in_temp_reading = '0;
  logic                 in_reading_fault = 1'b0;
  logic                 in_turn_up = 1'b0;
  logic                 in_left_button_down = 1'b0;
  logic                 in_right_button_down = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_heater_on;
  logic                 out_sensor_error;
  logic                 out_manual_mode;
  logic [TW-2:0]        out_target_temp;
  logic signed [TW-1:0] out_measured_temp;
  logic                 out_estop_fired;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_VALID;
  logic [CFG_DW-1:0]    cfg_data = '0;

  thermostat_hysteresis_safety_controller dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_temp_reading     (in_temp_reading),
    .in_reading_fault    (in_reading_fault),
    .in_turn_up          (in_turn_up),
    .in_left_button_down (in_left_button_down),
    .in_right_button_down(in_right_button_down),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_heater_on       (out_heater_on),
    .out_sensor_error    (out_sensor_error),
    .out_manual_mode     (out_manual_mode),
    .out_target_temp     (out_target_temp),
    .out_measured_temp   (out_measured_temp),
    .out_estop_fired     (out_estop_fired),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Configuration as the thermostat should currently see it.
  int lo_valid  = MIN_VALID_RST;
  int hi_valid  = MAX_VALID_RST;
  int limit_cfg = LIMIT_RST;
  int band_cfg  = BAND_RST;
  int step_cfg  = STEP_RST;
  int hold_cfg  = HOLD_RST;

  // Predicted controller state.
  bit manual_q     = 1'b0;
  bit heat_q       = 1'b0;
  bit err_q        = 1'b0;
  int meas_q       = 0;
  int target_q     = SETPOINT_RST;
  int hold_cnt     = 0;
  bit held_q       = 1'b0;
  bit stop_done_q  = 1'b0;

  ctl_word_t    pending_words[$];
  status_word_t expected_status[$];
  ctl_word_t    next_word;
  ctl_word_t    taken_word;
  status_word_t predicted;
  status_word_t popped;

  int error_count = 0;
  int idle_cycles = 0;
  bit in_taken    = 1'b0;
  bit no_idle     = 1'b0;
  int burst_req   = 0;
  int burst_done  = 0;
  int burst_left  = 0;

  // Clock: 8 time units per period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the thermostat state by one input word and form its status word.
  task automatic thermo_step(input ctl_word_t w, output status_word_t r);
    int t;
    bit fired;
    fired = 1'b0;
    case (w.op)
      OP_SAMPLE: begin
        t = w.temp;
        if (w.fault || t < lo_valid || t > hi_valid) begin
          err_q = 1'b1;
        end else begin
          err_q = 1'b0;
          meas_q = t;
        end
        // Heater decision with the safety overrides first.
        if (err_q || !manual_q || target_q > limit_cfg || meas_q >= limit_cfg) begin
          heat_q = 1'b0;
        end else if (meas_q < target_q - band_cfg) begin
          heat_q = 1'b1;
        end else if (meas_q > target_q) begin
          heat_q = 1'b0;
        end
      end
      OP_MODE: begin
        manual_q = !manual_q;
      end
      OP_SETPOINT: begin
        if (w.up) begin
          target_q = target_q + step_cfg;
          if (target_q > limit_cfg) target_q = limit_cfg;
        end else begin
          target_q = target_q - step_cfg;
          if (target_q < 0) target_q = 0;
        end
      end
      default: begin
        // Millisecond tick: both buttons held runs the emergency stop counter.
        if (w.left && w.right) begin
          if (!held_q) begin
            held_q = 1'b1;
            hold_cnt = 0;
          end else if (hold_cnt < HOLD_SAT) begin
            hold_cnt++;
          end
          if (hold_cnt >= hold_cfg && !stop_done_q) begin
            manual_q = 1'b0;
            heat_q = 1'b0;
            stop_done_q = 1'b1;
            fired = 1'b1;
          end
        end else begin
          hold_cnt = 0;
          held_q = 1'b0;
          stop_done_q = 1'b0;
        end
      end
    endcase
    r.heater   = heat_q;
    r.err      = err_q;
    r.manual   = manual_q;
    r.target   = target_q[TW-2:0];
    r.measured = meas_q[TW-1:0];
    r.estop    = fired;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Register write as the predictor applies it.
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    case (idx)
      CFG_MIN_VALID: lo_valid = $signed(data[TW-1:0]);
      CFG_MAX_VALID: hi_valid = $signed(data[TW-1:0]);
      CFG_LIMIT:     limit_cfg = data[TW-2:0];
      CFG_BAND:      band_cfg = data[BAND_W-1:0];
      CFG_STEP:      step_cfg = data[STEP_W-1:0];
      CFG_HOLD:      hold_cfg = data[HOLD_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Field value in the low bits, random junk in the bits the register ignores.
  function automatic logic [CFG_DW-1:0] junk_over(input int v, input int w);
    logic [CFG_DW-1:0] m;
    m = (CFG_DW'(1) << w) - CFG_DW'(1);
    return (CFG_DW'($urandom) & ~m) | (CFG_DW'(v) & m);
  endfunction

  task automatic set_regs(input int lo, input int hi, input int lim,
                          input int band, input int step, input int hold);
    write_reg(CFG_MIN_VALID, junk_over(lo, TW));
    write_reg(CFG_MAX_VALID, junk_over(hi, TW));
    write_reg(CFG_LIMIT, junk_over(lim, TW - 1));
    write_reg(CFG_BAND, junk_over(band, BAND_W));
    write_reg(CFG_STEP, junk_over(step, STEP_W));
    write_reg(CFG_HOLD, junk_over(hold, HOLD_CFG_W));
  endtask

  function automatic ctl_word_t mk(input logic [OP_W-1:0] op, input int temp,
                                   input bit fault, input bit up, input bit l, input bit r);
    ctl_word_t w;
    w.op = op;
    w.temp = temp[TW-1:0];
    w.fault = fault;
    w.up = up;
    w.left = l;
    w.right = r;
    return w;
  endfunction

  // Readings aimed at the thresholds that matter, plus fully random ones.
  function automatic logic [TW-1:0] pick_temp();
    int v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = target_q - band_cfg - 10 + $urandom_range(2 * band_cfg + 20);
      2: v = limit_cfg - 4 + $urandom_range(8);
      3: v = lo_valid - 2 + $urandom_range(4);
      4: v = hi_valid - 2 + $urandom_range(4);
      default: v = $urandom_range(400) - 200;
    endcase
    return v[TW-1:0];
  endfunction

  function automatic ctl_word_t rand_word();
    ctl_word_t w;
    int sel;
    w.temp  = pick_temp();
    w.fault = ($urandom_range(99) < 10);
    w.up    = $urandom_range(1);
    w.left  = $urandom_range(1);
    w.right = $urandom_range(1);
    sel = $urandom_range(99);
    if (sel < 45) w.op = OP_SAMPLE;
    else if (sel < 55) w.op = OP_MODE;
    else if (sel < 72) w.op = OP_SETPOINT;
    else w.op = OP_TICK;
    return w;
  endfunction

  // A two-button hold of n ticks, optionally with other words mixed in, then a release.
  function automatic int queue_hold(input int n, input bit mixed);
    ctl_word_t w;
    int count;
    count = 0;
    for (int i = 0; i < n; i++) begin
      if (mixed && $urandom_range(99) < 20) begin
        w = rand_word();
        if (w.op == OP_TICK) w.op = OP_SAMPLE;
        pending_words.push_back(w);
        count++;
      end
      w = rand_word();
      w.op = OP_TICK;
      w.left = 1'b1;
      w.right = 1'b1;
      pending_words.push_back(w);
      count++;
    end
    w = rand_word();
    w.op = OP_TICK;
    if (w.left && w.right) w.left = 1'b0;
    pending_words.push_back(w);
    return count + 1;
  endfunction

  task automatic fill_random(input int n);
    int added;
    int len;
    added = 0;
    while (added < n) begin
      if ($urandom_range(99) < 15) begin
        if (hold_cfg <= 40) len = $urandom_range(hold_cfg + 3, (hold_cfg > 2) ? hold_cfg - 2 : 1);
        else len = $urandom_range(12, 1);
        added += queue_hold(len, 1'b1);
      end else begin
        pending_words.push_back(rand_word());
        added++;
      end
    end
  endtask

  // Hold the sender back until every word sent has come back.
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Input driver: offers the next pending word, with random gaps unless no_idle is set.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_words.size() != 0 && (no_idle || $urandom_range(99) >= 32)) begin
        next_word = pending_words.pop_front();
        in_valid             <= 1'b1;
        in_op                <= next_word.op;
        in_temp_reading      <= next_word.temp;
        in_reading_fault     <= next_word.fault;
        in_turn_up           <= next_word.up;
        in_left_button_down  <= next_word.left;
        in_right_button_down <= next_word.right;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: random back pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (burst_left > 0) begin
      out_stall  <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (burst_req != burst_done) begin
      burst_done <= burst_req;
      burst_left <= LONG_HOLDOFF;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 32);
    end
  end

  // Monitor: check each result word against the oldest prediction, then predict new words.
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        $error("result word with no prediction waiting");
        error_count++;
      end else begin
        popped = expected_status.pop_front();
        check_field("heater_on", popped.heater, out_heater_on);
        check_field("sensor_error", popped.err, out_sensor_error);
        check_field("manual_mode", popped.manual, out_manual_mode);
        check_field("target_temp", popped.target, out_target_temp);
        check_field("measured_temp", popped.measured, out_measured_temp);
        check_field("estop_fired", popped.estop, out_estop_fired);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      taken_word.op    = in_op;
      taken_word.temp  = in_temp_reading;
      taken_word.fault = in_reading_fault;
      taken_word.up    = in_turn_up;
      taken_word.left  = in_left_button_down;
      taken_word.right = in_right_button_down;
      thermo_step(taken_word, predicted);
      expected_status.push_back(predicted);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    int lo;
    int hi;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at reset settings: thresholds, range edges, faults, every operation.
    pending_words.push_back(mk(OP_SAMPLE, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_MODE, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 100, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 395, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 401, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 392, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 391, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 300, 1, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, -1080, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, -1081, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 5600, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 5601, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, -8192, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 8191, 0, 1, 1, 1));
    pending_words.push_back(mk(OP_SETPOINT, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SETPOINT, 0, 0, 1, 0, 0));
    pending_words.push_back(mk(OP_TICK, 0, 0, 0, 1, 1));
    pending_words.push_back(mk(OP_TICK, 0, 0, 0, 1, 0));
    pending_words.push_back(mk(OP_TICK, 0, 0, 0, 0, 1));
    pending_words.push_back(mk(OP_TICK, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 5199, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_MODE, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_MODE, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 200, 0, 0, 0, 0));
    wait_drained();

    // Reset settings: a full-length default hold, random words, and a long result hold-off.
    void'(queue_hold(hold_cfg + 2, 1'b1));
    fill_random(40);
    burst_req = burst_req + 1;
    wait_drained();

    // Widest range and limit, largest band and step, stop on the first tick.
    set_regs(-8192, 8191, 8191, 255, 255, 0);
    pending_words.push_back(mk(OP_MODE, 0, 0, 0, 0, 0));
    for (int i = 0; i < 40; i++) pending_words.push_back(mk(OP_SETPOINT, 0, 0, 1, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 7935, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 7936, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, 8191, 0, 0, 0, 0));
    for (int i = 0; i < 40; i++) pending_words.push_back(mk(OP_SETPOINT, 0, 0, 0, 0, 0));
    fill_random(100);
    wait_drained();

    // Zero limit with the target left above it, no band, unit step and hold.
    set_regs(-8192, 8191, 0, 0, 1, 1);
    pending_words.push_back(mk(OP_MODE, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, -100, 0, 0, 0, 0));
    pending_words.push_back(mk(OP_SETPOINT, 0, 0, 1, 0, 0));
    pending_words.push_back(mk(OP_SAMPLE, -100, 0, 0, 0, 0));
    fill_random(80);
    wait_drained();

    // Inverted valid range rejects every reading.
    set_regs(100, -100, 3000, 16, 40, 3);
    fill_random(80);
    wait_drained();

    // Random settings, twice.
    for (int k = 0; k < 2; k++) begin
      lo = $urandom_range(3000) - 1500;
      hi = lo + $urandom_range(4000);
      set_regs(lo, hi, $urandom_range(8191), $urandom_range(255), $urandom_range(255),
               $urandom_range(12, 1));
      fill_random(100);
      wait_drained();
    end

    // Spare indexes, then a full hold and random words with no idling.
    write_reg(CFG_SPARE_6, CFG_DW'($urandom));
    write_reg(CFG_SPARE_7, CFG_DW'($urandom));
    set_regs(MIN_VALID_RST, MAX_VALID_RST, LIMIT_RST, BAND_RST, STEP_RST, NOIDLE_HOLD);
    no_idle = 1'b1;
    pending_words.push_back(mk(OP_MODE, 0, 0, 0, 0, 0));
    void'(queue_hold(NOIDLE_HOLD + 4, 1'b0));
    fill_random(60);
    wait_drained();
    no_idle = 1'b0;
    fill_random(40);
    wait_drained();

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/thc_pkg.sv
hdl/thermostat_hysteresis_safety_controller.sv
dv/tb_thermostat_hysteresis_safety_controller.sv
